// ===== rtl/mhpq_pkg.sv =====
// Package for the max-heap priority queue.
// Holds default sizes, command and status codes, and the controller/datapath structs.
// No dependencies.
package mhpq_pkg;

    localparam int HEAP_DEPTH_DEF = 1024;
    localparam int KEY_WIDTH_DEF  = 32;

    // Port widths fixed by the item format
    localparam int IN_KEY_W  = 32;
    localparam int OUT_KEY_W = 32;
    localparam int TOTAL_W   = 11;
    localparam int STATUS_W  = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        RD_PARENT,
        RD_LAST,
        RD_CHILD
    } rd_sel_t;

    typedef struct packed {
        logic    start;        // take the input item
        rd_sel_t rd_sel;       // which slot(s) to read
        logic    load_key;     // moving key <= read data (last slot)
        logic    place_key;    // write moving key at the hole
        logic    move_parent;  // parent drops into the hole, hole moves up
        logic    move_child;   // larger child rises into the hole, hole moves down
        logic    finish;       // load the result register
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic last_one;
        logic pos_zero;
        logic left_absent;
        logic parent_smaller;
        logic child_bigger;
        logic out_busy;
    } dp_stat_t;

endpackage

// ===== rtl/mhpq_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/mhpq_dp.sv =====
// Datapath of the max-heap priority queue: key memory, count, hole position,
// moving key, root mirror and result register. Uses mhpq_pkg and mhpq_ram.
module mhpq_dp #(
    parameter int HEAP_DEPTH = mhpq_pkg::HEAP_DEPTH_DEF,
    parameter int KEY_WIDTH  = mhpq_pkg::KEY_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mhpq_pkg::dp_cmd_t                     ctl,
    output mhpq_pkg::dp_stat_t                    stat,
    input  logic                                  cmd,
    input  logic signed [mhpq_pkg::IN_KEY_W-1:0]  new_priority,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [mhpq_pkg::STATUS_W-1:0]         status,
    output logic signed [mhpq_pkg::OUT_KEY_W-1:0] removed_priority,
    output logic signed [mhpq_pkg::OUT_KEY_W-1:0] top_priority,
    output logic                                  top_valid,
    output logic [mhpq_pkg::TOTAL_W-1:0]          element_total
);
    import mhpq_pkg::*;

    localparam int AW  = $clog2(HEAP_DEPTH);
    localparam int CW  = $clog2(HEAP_DEPTH + 1);
    localparam int CHW = AW + 2;

    logic [CW-1:0]        count_reg;
    logic [AW-1:0]        pos_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] top_reg;
    logic [KEY_WIDTH-1:0] removed_reg;
    logic [STATUS_W-1:0]  status_reg;

    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [OUT_KEY_W-1:0] out_removed_reg;
    logic [OUT_KEY_W-1:0] out_top_reg;
    logic                 out_top_valid_reg;
    logic [TOTAL_W-1:0]   out_total_reg;

    logic                 full;
    logic                 empty;
    logic [AW-1:0]        parent_addr;
    logic [CHW-1:0]       left_w;
    logic [CHW-1:0]       count_w;
    logic [AW-1:0]        left_addr;
    logic [AW-1:0]        right_addr;
    logic                 right_exists;
    logic [AW-1:0]        raddr_a;
    logic [KEY_WIDTH-1:0] rdata_a;
    logic [KEY_WIDTH-1:0] rdata_b;
    logic                 big_right;
    logic [KEY_WIDTH-1:0] big_data;
    logic                 we;
    logic [KEY_WIDTH-1:0] wdata;

    assign full        = (count_reg == CW'(HEAP_DEPTH));
    assign empty       = (count_reg == '0);
    assign parent_addr = AW'((pos_reg - AW'(1)) >> 1);
    assign left_w      = CHW'({pos_reg, 1'b1});
    assign count_w     = CHW'(count_reg);
    assign left_addr   = left_w[AW-1:0];
    assign right_addr  = left_addr + AW'(1);
    assign right_exists = (left_w + CHW'(1)) < count_w;

    always_comb
    begin
        unique case (ctl.rd_sel)
            RD_PARENT: raddr_a = parent_addr;
            RD_LAST:   raddr_a = AW'(count_reg);
            RD_CHILD:  raddr_a = left_addr;
            default:   raddr_a = left_addr;
        endcase
    end

    // Equal children pick the left one
    assign big_right = right_exists && ($signed(rdata_b) > $signed(rdata_a));
    assign big_data  = big_right ? rdata_b : rdata_a;

    assign we = ctl.place_key | ctl.move_parent | ctl.move_child;

    always_comb
    begin
        if (ctl.move_parent)
        begin
            wdata = rdata_a;
        end
        else if (ctl.move_child)
        begin
            wdata = big_data;
        end
        else
        begin
            wdata = key_reg;
        end
    end

    mhpq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (pos_reg),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (right_addr),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        stat.full           = full;
        stat.empty          = empty;
        stat.last_one       = (count_reg == CW'(1));
        stat.pos_zero       = (pos_reg == '0);
        stat.left_absent    = (left_w >= count_w);
        stat.parent_smaller = $signed(key_reg) > $signed(rdata_a);
        stat.child_bigger   = $signed(big_data) > $signed(key_reg);
        stat.out_busy       = out_valid_reg && out_stall;
    end

    // Working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.start)
        begin
            if (cmd == CMD_INSERT && !full)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd == CMD_REMOVE && !empty)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            key_reg <= KEY_WIDTH'(new_priority);
            if (cmd == CMD_INSERT)
            begin
                pos_reg     <= AW'(count_reg);
                removed_reg <= '0;
                status_reg  <= full ? ST_FULL : ST_OK;
            end
            else
            begin
                pos_reg     <= '0;
                removed_reg <= empty ? '0 : top_reg;
                status_reg  <= empty ? ST_EMPTY : ST_OK;
            end
        end
        else
        begin
            if (ctl.load_key)
            begin
                key_reg <= rdata_a;
            end
            if (ctl.move_parent)
            begin
                pos_reg <= parent_addr;
            end
            else if (ctl.move_child)
            begin
                pos_reg <= big_right ? right_addr : left_addr;
            end
        end
        // Mirror every root write so the top key is always at hand
        if (we && pos_reg == '0)
        begin
            top_reg <= wdata;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            out_status_reg    <= status_reg;
            out_removed_reg   <= OUT_KEY_W'(removed_reg);
            out_top_reg       <= empty ? '0 : OUT_KEY_W'(top_reg);
            out_top_valid_reg <= !empty;
            out_total_reg     <= TOTAL_W'(count_reg);
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign removed_priority = out_removed_reg;
    assign top_priority     = out_top_reg;
    assign top_valid        = out_top_valid_reg;
    assign element_total    = out_total_reg;

endmodule

// ===== rtl/mhpq_ctrl.sv =====
// Controller of the max-heap priority queue: sequences sift-up and sift-down
// one tree level at a time. Uses mhpq_pkg.
module mhpq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  mhpq_pkg::dp_stat_t stat,
    output mhpq_pkg::dp_cmd_t  ctl
);
    import mhpq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_LAST,
        S_DN_LOAD,
        S_DN_RD,
        S_DN_CMP,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;

    always_comb
    begin
        state_next      = state_reg;
        ctl.start       = 1'b0;
        ctl.rd_sel      = RD_CHILD;
        ctl.load_key    = 1'b0;
        ctl.place_key   = 1'b0;
        ctl.move_parent = 1'b0;
        ctl.move_child  = 1'b0;
        ctl.finish      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.start = 1'b1;
                    if (cmd == CMD_INSERT)
                    begin
                        state_next = stat.full ? S_FINISH : S_UP_RD;
                    end
                    else
                    begin
                        // Removing the only key leaves nothing to repair
                        state_next = (stat.empty || stat.last_one) ? S_FINISH : S_DN_LAST;
                    end
                end
            end
            S_UP_RD:
            begin
                ctl.rd_sel = RD_PARENT;
                if (stat.pos_zero)
                begin
                    ctl.place_key = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.parent_smaller)
                begin
                    ctl.move_parent = 1'b1;
                    state_next      = S_UP_RD;
                end
                else
                begin
                    ctl.place_key = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_DN_LAST:
            begin
                ctl.rd_sel = RD_LAST;
                state_next = S_DN_LOAD;
            end
            S_DN_LOAD:
            begin
                ctl.load_key = 1'b1;
                state_next   = S_DN_RD;
            end
            S_DN_RD:
            begin
                ctl.rd_sel = RD_CHILD;
                if (stat.left_absent)
                begin
                    ctl.place_key = 1'b1;
                    state_next    = S_FINISH;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                if (stat.child_bigger)
                begin
                    ctl.move_child = 1'b1;
                    state_next     = S_DN_RD;
                end
                else
                begin
                    ctl.place_key = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // Hold until the result register is free
                if (!stat.out_busy)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != S_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

endmodule

// ===== rtl/max_heap_priority_queue.sv =====
// Max-heap priority queue of signed keys, one result item per command item, one at a time.
// A refusal or the removal of the only key goes straight to the finish state; an insert walks
// up the tree, and a removal first loads the last key and then walks down, one read-compare-write
// step per level. The next item is taken in the cycle after the result is loaded, so no item is
// taken before the last one is through; a stalled output holds the block in its finish state.
// Reset clears the count, controller and result valid; the key memory is not cleared.
module max_heap_priority_queue #(
    parameter int HEAP_DEPTH = mhpq_pkg::HEAP_DEPTH_DEF,
    parameter int KEY_WIDTH  = mhpq_pkg::KEY_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  cmd,
    input  logic signed [mhpq_pkg::IN_KEY_W-1:0]  new_priority,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [mhpq_pkg::STATUS_W-1:0]         status,
    output logic signed [mhpq_pkg::OUT_KEY_W-1:0] removed_priority,
    output logic signed [mhpq_pkg::OUT_KEY_W-1:0] top_priority,
    output logic                                  top_valid,
    output logic [mhpq_pkg::TOTAL_W-1:0]          element_total
);
    import mhpq_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    mhpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat),
        .ctl      (ctl)
    );

    mhpq_dp #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .stat             (stat),
        .cmd              (cmd),
        .new_priority     (new_priority),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .removed_priority (removed_priority),
        .top_priority     (top_priority),
        .top_valid        (top_valid),
        .element_total    (element_total)
    );

endmodule

// ===== rtl/mhpq_check.sv =====
// Port-level checks for the max-heap priority queue, bound to the top level.
// Uses mhpq_pkg.
module mhpq_check (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic                                  cmd,
    input logic signed [mhpq_pkg::IN_KEY_W-1:0]  new_priority,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic [mhpq_pkg::STATUS_W-1:0]         status,
    input logic signed [mhpq_pkg::OUT_KEY_W-1:0] removed_priority,
    input logic signed [mhpq_pkg::OUT_KEY_W-1:0] top_priority,
    input logic                                  top_valid,
    input logic [mhpq_pkg::TOTAL_W-1:0]          element_total
);
    import mhpq_pkg::*;

    // A stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(removed_priority) && $stable(top_priority)
            && $stable(element_total))
        else $error("result changed while stalled");

    // An empty heap reports no top key and no count
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !top_valid |-> element_total == '0 && top_priority == '0)
        else $error("empty heap shows a top key or a count");

    // A refused command removes nothing
    a_refused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> removed_priority == '0)
        else $error("refused command reports a removed key");

    // A full refusal implies keys are held, an empty refusal implies none
    a_refusal_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL || status == ST_EMPTY)
            |-> top_valid == (status == ST_FULL))
        else $error("refusal status disagrees with heap occupancy");

    logic unused_in;
    assign unused_in = in_valid ^ in_stall ^ cmd ^ new_priority[0];

endmodule

bind max_heap_priority_queue mhpq_check u_mhpq_check (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for max_heap_priority_queue: a directed table followed by random insert and
// remove items, each result checked against the table's values or a heap predictor in the bench.
// Depends on mhpq_pkg and the max_heap_priority_queue RTL.
module tb;
    import mhpq_pkg::*;

    localparam int QUEUE_SLOTS = HEAP_DEPTH_DEF;
    localparam int unsigned CLIMB_TOP = 160;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic signed [IN_KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [IN_KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [STATUS_W-1:0]  code;
        logic [OUT_KEY_W-1:0] removed;
        logic [OUT_KEY_W-1:0] top;
        logic                 occupied;
        logic [TOTAL_W-1:0]   total;
    } heap_result_t;

    typedef struct packed {
        logic                        op;
        logic signed [IN_KEY_W-1:0]  key;
        logic                        typed;
        heap_result_t                want;
    } heap_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic                         cmd = CMD_INSERT;
    logic signed [IN_KEY_W-1:0]   new_priority = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [STATUS_W-1:0]          status;
    logic signed [OUT_KEY_W-1:0]  removed_priority;
    logic signed [OUT_KEY_W-1:0]  top_priority;
    logic                         top_valid;
    logic [TOTAL_W-1:0]           element_total;

    // predictor state
    logic signed [IN_KEY_W-1:0]   pq_keys [QUEUE_SLOTS];
    int unsigned                  pq_count = 0;

    heap_result_t                 heap_expect [$];
    heap_row_t                    plan [$];
    int                           mismatch_count = 0;
    int                           results_seen = 0;
    int                           items_offered = 0;
    int                           gap_pct = 20;
    int unsigned                  cycle_count = 0;
    bit                           calm = 1'b0;
    bit                           pressure_done = 1'b0;

    max_heap_priority_queue dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .new_priority     (new_priority),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .removed_priority (removed_priority),
        .top_priority     (top_priority),
        .top_valid        (top_valid),
        .element_total    (element_total)
    );

    always #4 clk = ~clk;

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("max_heap_priority_queue test failed");
            $finish;
        end
    end

    // Apply one command to the predicted heap and return the result it should produce.
    function automatic heap_result_t apply_heap_op(logic op, logic signed [IN_KEY_W-1:0] key);
        heap_result_t               r;
        int unsigned                pos;
        int unsigned                up;
        int unsigned                left;
        int unsigned                big;
        logic signed [IN_KEY_W-1:0] hold;
        r = '0;
        r.code = ST_OK;
        if (op == CMD_INSERT)
        begin
            if (pq_count >= QUEUE_SLOTS)
                r.code = ST_FULL;
            else
            begin
                pos = pq_count;
                pq_keys[pos] = key;
                pq_count++;
                while (pos > 0)
                begin
                    up = (pos - 1) / 2;
                    if (pq_keys[pos] <= pq_keys[up])
                        break;
                    hold = pq_keys[up];
                    pq_keys[up] = pq_keys[pos];
                    pq_keys[pos] = hold;
                    pos = up;
                end
            end
        end
        else if (pq_count == 0)
            r.code = ST_EMPTY;
        else
        begin
            r.removed = pq_keys[0];
            pq_count--;
            pq_keys[0] = pq_keys[pq_count];
            pos = 0;
            while (1)
            begin
                left = 2 * pos + 1;
                if (left >= pq_count)
                    break;
                big = left;
                // right child wins only when strictly greater
                if (left + 1 < pq_count && pq_keys[left + 1] > pq_keys[left])
                    big = left + 1;
                if (!(pq_keys[big] > pq_keys[pos]))
                    break;
                hold = pq_keys[big];
                pq_keys[big] = pq_keys[pos];
                pq_keys[pos] = hold;
                pos = big;
            end
        end
        r.occupied = (pq_count != 0);
        r.top = r.occupied ? pq_keys[0] : '0;
        r.total = TOTAL_W'(pq_count);
        return r;
    endfunction

    function automatic heap_row_t open_row(logic op, logic signed [IN_KEY_W-1:0] key);
        heap_row_t r;
        r = '0;
        r.op = op;
        r.key = key;
        return r;
    endfunction

    function automatic heap_row_t typed_row(logic op, logic signed [IN_KEY_W-1:0] key,
                                           logic [STATUS_W-1:0] code,
                                           logic signed [OUT_KEY_W-1:0] removed,
                                           logic signed [OUT_KEY_W-1:0] top,
                                           logic [TOTAL_W-1:0] total);
        heap_row_t r;
        r.op = op;
        r.key = key;
        r.typed = 1'b1;
        r.want.code = code;
        r.want.removed = removed;
        r.want.top = top;
        r.want.occupied = (total != 0);
        r.want.total = total;
        return r;
    endfunction

    function automatic logic signed [IN_KEY_W-1:0] pick_key();
        logic signed [IN_KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: k = $signed(IN_KEY_W'($urandom_range(0, 8))) - 4;
            4, 5:
            begin
                case ($urandom_range(0, 6))
                    0: k = KEY_MIN;
                    1: k = KEY_MIN + 1;
                    2: k = -1;
                    3: k = 0;
                    4: k = 1;
                    5: k = KEY_MAX - 1;
                    default: k = KEY_MAX;
                endcase
            end
            default: k = $urandom;
        endcase
        return k;
    endfunction

    function automatic void flag_error(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at result %0d: %s", results_seen, msg);
    endfunction

    // Present one item, hold it until taken, then record what it should produce.
    task automatic offer(input logic op, input logic signed [IN_KEY_W-1:0] key,
                         input logic typed, input heap_result_t want);
        heap_result_t r;
        if (items_offered % 40 == 0)
        begin
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 20;
                default: gap_pct = 60;
            endcase
        end
        items_offered++;
        if (!calm && $urandom_range(1, 100) <= gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        new_priority <= key;
        do
            @(posedge clk);
        while (in_stall);
        r = apply_heap_op(op, key);
        heap_expect.push_back(typed ? want : r);
    endtask

    task automatic mixed_run(input int n, input int insert_pct);
        repeat (n)
            offer(($urandom_range(1, 100) <= insert_pct) ? CMD_INSERT : CMD_REMOVE,
                  pick_key(), 1'b0, '0);
    endtask

    initial
    begin : drive
        plan.push_back(typed_row(CMD_REMOVE, 32'sh1234_5678, ST_EMPTY, 0, 0, 0));
        plan.push_back(typed_row(CMD_INSERT, KEY_MIN, ST_OK, 0, KEY_MIN, 1));
        plan.push_back(typed_row(CMD_INSERT, KEY_MAX, ST_OK, 0, KEY_MAX, 2));
        plan.push_back(open_row(CMD_INSERT, 0));
        plan.push_back(open_row(CMD_INSERT, -1));
        // second maximum stops below the equal root
        plan.push_back(open_row(CMD_INSERT, KEY_MAX));
        plan.push_back(open_row(CMD_INSERT, 5));
        plan.push_back(open_row(CMD_INSERT, 5));
        plan.push_back(typed_row(CMD_REMOVE, -1, ST_OK, KEY_MAX, KEY_MAX, 6));
        repeat (5) plan.push_back(open_row(CMD_REMOVE, KEY_MAX));
        plan.push_back(typed_row(CMD_REMOVE, 7, ST_OK, KEY_MIN, 0, 0));
        plan.push_back(typed_row(CMD_REMOVE, KEY_MIN, ST_EMPTY, 0, 0, 0));
        repeat (3) plan.push_back(open_row(CMD_INSERT, 3));
        plan.push_back(open_row(CMD_REMOVE, 0));
        plan.push_back(open_row(CMD_INSERT, 32'sh5555_5555));
        plan.push_back(open_row(CMD_INSERT, 32'shAAAA_AAAA));

        wait (rst_n);
        @(posedge clk);
        foreach (plan[i])
            offer(plan[i].op, plan[i].key, plan[i].typed, plan[i].want);

        mixed_run(250, 55);
        // climb to a deep heap, then drain it and knock on the empty heap
        while (pq_count < CLIMB_TOP)
            offer(($urandom_range(0, 19) == 0) ? CMD_REMOVE : CMD_INSERT, pick_key(), 1'b0, '0);
        while (pq_count > 0)
            offer(($urandom_range(0, 19) == 0) ? CMD_INSERT : CMD_REMOVE, pick_key(), 1'b0, '0);
        repeat (2) offer(CMD_REMOVE, pick_key(), 1'b0, '0);

        calm = 1'b1;
        mixed_run(100, 55);
        in_valid <= 1'b0;

        while (heap_expect.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
            $display("max_heap_priority_queue test passed");
        else
            $display("max_heap_priority_queue test failed");
        $finish;
    end

    initial
    begin : hold_results
        int pct;
        pct = 20;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (!pressure_done && results_seen >= 40)
            begin
                // long hold so the block backs up into its input
                pressure_done = 1'b1;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(1, 100) <= pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 63) == 0)
                pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
        end
    end

    always @(posedge clk)
    begin : watch
        heap_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (heap_expect.size() == 0)
                flag_error("result with nothing expected");
            else
            begin
                want = heap_expect.pop_front();
                if (status !== want.code)
                    flag_error($sformatf("status expected %0d, got %0d", want.code, status));
                if (removed_priority !== want.removed)
                    flag_error($sformatf("removed_priority expected %0d, got %0d",
                                         $signed(want.removed), removed_priority));
                if (top_priority !== want.top)
                    flag_error($sformatf("top_priority expected %0d, got %0d",
                                         $signed(want.top), top_priority));
                if (top_valid !== want.occupied)
                    flag_error($sformatf("top_valid expected %0d, got %0d",
                                         want.occupied, top_valid));
                if (element_total !== want.total)
                    flag_error($sformatf("element_total expected %0d, got %0d",
                                         want.total, element_total));
            end
            results_seen++;
        end
    end

endmodule
